// File: rtl/ugc_pkg.sv
// shared types, constants and helpers for the used-glyph collector
// no dependencies; used by ugc_decode and the collector core

package ugc_pkg;

  // default code space and presence map row geometry
  localparam int CODE_SPACE_DEF = 65536;
  localparam int MAP_WORD       = 32;
  localparam int MAP_OFS_W      = 5;

  // request opcodes
  localparam logic [1:0] OP_FEED    = 2'd0;
  localparam logic [1:0] OP_FETCH   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] byte_value;
  } in_req_t;

  typedef struct packed {
    logic [15:0] code_point;
    logic        found;
  } out_res_t;

  // completed code point from the decoder
  typedef struct packed {
    logic        vld;
    logic [15:0] cp;
  } mark_t;

  // index of the lowest set bit of one map row
  function automatic logic [MAP_OFS_W-1:0] lowest_bit(input logic [MAP_WORD-1:0] w);
    logic [MAP_OFS_W-1:0] idx;
    idx = '0;
    for (int i = MAP_WORD - 1; i >= 0; i--) begin
      if (w[i]) idx = MAP_OFS_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: rtl/ugc_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no dependencies

module ugc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: rtl/ugc_decode.sv
// utf-8 byte decoder: lead classification, continuation gathering, halt on stray continuation
// depends on ugc_pkg

module ugc_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          feed,
  input  logic [7:0]    byte_in,
  output ugc_pkg::mark_t mark
);

  logic [1:0]  rem_r, rem_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic        halt_r, halt_nxt;
  logic [15:0] pc_cat;
  logic [1:0]  rem_dec;

  assign pc_cat  = {pc_r[9:0], byte_in[5:0]};
  assign rem_dec = rem_r - 2'd1;

  always_comb begin
    rem_nxt  = rem_r;
    len_nxt  = len_r;
    pc_nxt   = pc_r;
    halt_nxt = halt_r;
    mark     = '0;
    if (feed) begin
      priority if (byte_in == 8'h00) begin
        rem_nxt  = '0;
        len_nxt  = '0;
        pc_nxt   = '0;
        halt_nxt = 1'b0;
      end else if (halt_r) begin
        halt_nxt = 1'b1;
      end else if (rem_r != 2'd0) begin
        // continuation byte, top bits not checked
        pc_nxt  = pc_cat;
        rem_nxt = rem_dec;
        if (rem_dec == 2'd0) begin
          mark.vld = (len_r <= 3'd3);
          mark.cp  = pc_cat;
          rem_nxt  = '0;
          len_nxt  = '0;
          pc_nxt   = '0;
        end
      end else if (byte_in[7:4] == 4'hF) begin
        len_nxt = 3'd4;
        rem_nxt = 2'd3;
        pc_nxt  = '0;
      end else if (byte_in[7:5] == 3'b111) begin
        len_nxt = 3'd3;
        rem_nxt = 2'd2;
        pc_nxt  = {12'd0, byte_in[3:0]};
      end else if (byte_in[7:6] == 2'b11) begin
        len_nxt = 3'd2;
        rem_nxt = 2'd1;
        pc_nxt  = {11'd0, byte_in[4:0]};
      end else if (!byte_in[7]) begin
        mark.vld = 1'b1;
        mark.cp  = {8'd0, byte_in};
        rem_nxt  = '0;
        len_nxt  = '0;
        pc_nxt   = '0;
      end else begin
        // stray continuation in lead position
        halt_nxt = 1'b1;
        rem_nxt  = '0;
        len_nxt  = '0;
        pc_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      len_r  <= '0;
      pc_r   <= '0;
      halt_r <= 1'b0;
    end else begin
      rem_r  <= rem_nxt;
      len_r  <= len_nxt;
      pc_r   <= pc_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

// File: rtl/utf8_used_glyph_collector_core.sv
// top level of the used-glyph collector: utf-8 decode, presence map ram, ordered readout
// depends on ugc_pkg, ugc_decode and ugc_ram
//
//   channel  direction  handshake            payload
//   in_      in         in_valid / in_stall  ugc_pkg::in_req_t  (opcode, byte_value)
//   out_     out        out_valid/out_stall  ugc_pkg::out_res_t (code_point, found)
//
// feeds may follow one another every cycle while in_stall is low
// a fetch scans the map one 32-bit row at a time (read, then check in the
//   single read port of the map ram)
// a restart returns the readout cursor to zero
// after reset a clearing pass writes zero to every map row (2048 rows by default),
//   one row a cycle, with in_stall high
// a result waits in the output register while out_stall is high; feeds go on,
//   and a later fetch holds its result until the output register frees up

module utf8_used_glyph_collector_core #(
  parameter int CODE_SPACE = ugc_pkg::CODE_SPACE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ugc_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ugc_pkg::out_res_t out_data
);

  localparam int WW    = ugc_pkg::MAP_WORD;
  localparam int OW    = ugc_pkg::MAP_OFS_W;
  localparam int DEPTH = (CODE_SPACE + WW - 1) / WW;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(CODE_SPACE) + 1;
  localparam logic [CW-1:0] CUR_END  = CW'(CODE_SPACE);
  localparam logic [AW-1:0] LAST_ROW = AW'(DEPTH - 1);
  localparam logic [16:0]   CP_LIMIT = 17'(CODE_SPACE);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_HOLD
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [CW-1:0]     cursor_r, cursor_nxt;
  logic              out_valid_r, out_valid_nxt;
  ugc_pkg::out_res_t out_data_r, out_data_nxt;
  ugc_pkg::out_res_t pend_r, pend_nxt;

  // request decode
  logic in_acc, feed, fetch, restart;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign feed     = in_acc && (in_data.opcode == ugc_pkg::OP_FEED);
  assign fetch    = in_acc && (in_data.opcode == ugc_pkg::OP_FETCH);
  assign restart  = in_acc && (in_data.opcode == ugc_pkg::OP_RESTART);

  // utf-8 decoder
  ugc_pkg::mark_t mark;
  logic           mark_ok;

  ugc_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .feed    (feed),
    .byte_in (in_data.byte_value),
    .mark    (mark)
  );

  // zero is never marked, nor anything beyond the code space
  assign mark_ok = mark.vld && (mark.cp != 16'd0) && ({1'b0, mark.cp} < CP_LIMIT);

  // map ram ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, ram_rdata;

  ugc_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // mark pipeline: read issued with the feed, modify and write in the cycle after
  logic          m_vld_r;
  logic [AW-1:0] m_addr_r;
  logic [OW-1:0] m_ofs_r;
  // last write, forwarded when the read it raced with hits the same row
  logic          fw_vld_r;
  logic [AW-1:0] fw_addr_r;
  logic [WW-1:0] fw_data_r;
  logic [WW-1:0] m_base, m_word;

  assign m_base = (fw_vld_r && (fw_addr_r == m_addr_r)) ? fw_data_r : ram_rdata;
  assign m_word = m_base | (WW'(1) << m_ofs_r);

  // cursor split into map row and bit within the row
  logic [AW-1:0] cur_row;
  logic [OW-1:0] cur_ofs;
  logic          cur_end;
  assign cur_row = cursor_r[AW+OW-1:OW];
  assign cur_ofs = cursor_r[OW-1:0];
  assign cur_end = (cursor_r >= CUR_END);

  // row check during a scan
  logic [WW-1:0] chk_masked;
  logic          chk_hit;
  logic [OW-1:0] chk_ofs;
  logic [CW-1:0] hit_cp, hit_next, row_next;
  assign chk_masked = ram_rdata & ({WW{1'b1}} << cur_ofs);
  assign chk_hit    = |chk_masked;
  assign chk_ofs    = ugc_pkg::lowest_bit(chk_masked);
  assign hit_cp     = CW'({cur_row, chk_ofs});
  assign hit_next   = hit_cp + CW'(1);
  assign row_next   = CW'({cur_row, {OW{1'b0}}}) + CW'(WW);

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // ram port selection; clearing and marking never overlap
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = m_addr_r;
    ram_wdata = m_word;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (m_vld_r) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    if (state_r == S_SCAN_RD) begin
      ram_re    = !cur_end;
      ram_raddr = cur_row;
    end else begin
      ram_re    = mark_ok;
      ram_raddr = mark.cp[AW+OW-1:OW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r  <= 1'b0;
      fw_vld_r <= 1'b0;
    end else begin
      m_vld_r  <= mark_ok;
      fw_vld_r <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    m_addr_r  <= mark.cp[AW+OW-1:OW];
    m_ofs_r   <= mark.cp[OW-1:0];
    fw_addr_r <= ram_waddr;
    fw_data_r <= ram_wdata;
  end

  // readout sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cursor_nxt    = cursor_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ROW) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (restart) cursor_nxt = '0;
        if (fetch)   state_nxt  = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (cur_end) begin
          // list exhausted
          cursor_nxt = CUR_END;
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            state_nxt     = S_IDLE;
          end else begin
            pend_nxt  = '0;
            state_nxt = S_HOLD;
          end
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (chk_hit) begin
          cursor_nxt = hit_next;
          if (out_free) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.code_point = 16'(hit_cp);
            out_data_nxt.found      = 1'b1;
            state_nxt               = S_IDLE;
          end else begin
            pend_nxt.code_point = 16'(hit_cp);
            pend_nxt.found      = 1'b1;
            state_nxt           = S_HOLD;
          end
        end else begin
          cursor_nxt = (row_next >= CUR_END) ? CUR_END : row_next;
          state_nxt  = S_SCAN_RD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pend_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    pend_r     <= pend_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // no mark write may race the scan reads
  a_scan_no_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_RD || state_r == S_SCAN_CHK) |-> !m_vld_r)
    else $error("mark write pending during readout scan");

  // clearing pass owns the write port and produces nothing
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!m_vld_r && !out_valid_r))
    else $error("activity during map clearing pass");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CUR_END)
    else $error("readout cursor beyond code space");

  a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |-> (out_data_r.code_point == 16'd0))
    else $error("exhausted result carries a code point");

  // a direct hit leaves the cursor just past the returned code point
  a_hit_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_CHK && chk_hit && out_free) |=>
      (out_valid_r && out_data_r.found &&
       (cursor_r == CW'(out_data_r.code_point) + CW'(1))))
    else $error("cursor not advanced past returned code point");

endmodule
